@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the aging page replacement unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define APR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define APR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ hdl/apr_pkg.sv @@
// ----------------------------------------------------------------------------
// apr_pkg
// Constants and control types shared by the aging page replacement modules.
// ----------------------------------------------------------------------------
`default_nettype none

package apr_pkg;

   localparam int DEF_FRAME_COUNT  = 8;
   localparam int DEF_PAGE_BITS    = 16;
   localparam int DEF_COUNTER_BITS = 16;

   localparam int HIST_BITS        = 4;
   localparam int FRAME_IDX_BITS   = 3;
   localparam int FAULT_BITS       = 32;

   localparam logic [HIST_BITS-1:0] HIST_RESET = 4'd10;

   typedef struct packed {
      logic wr_en;
      logic page_wr;
      logic set_valid;
      logic clear_all;
   } ram_ctrl_type;

   typedef struct packed {
      logic start;
      logic step;
   } scan_ctrl_type;

endpackage

`default_nettype wire

@@ hdl/apr_frame_ram.sv @@
// ----------------------------------------------------------------------------
// apr_frame_ram
// Frame page and age memory with one write port and one registered read
// port, plus per-frame valid bits that a run end clears at once.
// ----------------------------------------------------------------------------
`default_nettype none

module apr_frame_ram
   import apr_pkg::*;
#(
   parameter int FRAME_COUNT  = DEF_FRAME_COUNT,
   parameter int PAGE_BITS    = DEF_PAGE_BITS,
   parameter int COUNTER_BITS = DEF_COUNTER_BITS,
   parameter int IDX_BITS     = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ram_ctrl_type            ctrl,
   input  wire logic [IDX_BITS-1:0]     wr_addr,
   input  wire logic [PAGE_BITS-1:0]    wr_page,
   input  wire logic [COUNTER_BITS-1:0] wr_age,
   input  wire logic [IDX_BITS-1:0]     rd_addr,
   output logic                         rd_valid,
   output logic [PAGE_BITS-1:0]         rd_page,
   output logic [COUNTER_BITS-1:0]      rd_age
);

   logic [PAGE_BITS-1:0]    page_mem [FRAME_COUNT];
   logic [COUNTER_BITS-1:0] age_mem  [FRAME_COUNT];
   logic [FRAME_COUNT-1:0]  valid_ff;
   logic                    rd_valid_ff;
   logic [PAGE_BITS-1:0]    rd_page_ff;
   logic [COUNTER_BITS-1:0] rd_age_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         age_mem[wr_addr] <= wr_age;
      end
      if (ctrl.page_wr) begin
         page_mem[wr_addr] <= wr_page;
      end
      rd_page_ff <= page_mem[rd_addr];
      rd_age_ff  <= age_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (ctrl.clear_all) begin
            valid_ff <= '0;
         end else if (ctrl.set_valid) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // An empty frame has never been referenced, so its age reads as zero.
   assign rd_valid = rd_valid_ff;
   assign rd_page  = rd_page_ff;
   assign rd_age   = rd_valid_ff ? rd_age_ff : '0;

endmodule

`default_nettype wire

@@ hdl/apr_scan_unit.sv @@
// ----------------------------------------------------------------------------
// apr_scan_unit
// Shared compare unit that takes one frame per step, decays its age and
// tracks the first matching frame and the first frame with the lowest decayed age seen so far.
// ----------------------------------------------------------------------------
`default_nettype none

module apr_scan_unit
   import apr_pkg::*;
#(
   parameter int PAGE_BITS    = DEF_PAGE_BITS,
   parameter int COUNTER_BITS = DEF_COUNTER_BITS,
   parameter int IDX_BITS     = 3
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire scan_ctrl_type           ctrl,
   input  wire logic [IDX_BITS-1:0]     frame_idx,
   input  wire logic                    frame_valid,
   input  wire logic [PAGE_BITS-1:0]    frame_page,
   input  wire logic [COUNTER_BITS-1:0] frame_age,
   input  wire logic [PAGE_BITS-1:0]    req_page,
   output logic [COUNTER_BITS-1:0]      decayed_age,
   output logic                         found,
   output logic [IDX_BITS-1:0]          sel_idx,
   output logic [COUNTER_BITS-1:0]      sel_age
);

   logic                    found_ff;
   logic [IDX_BITS-1:0]     hit_idx_ff;
   logic [COUNTER_BITS-1:0] hit_age_ff;
   logic [IDX_BITS-1:0]     min_idx_ff;
   logic [COUNTER_BITS-1:0] best_ff;
   logic                    match;
   logic                    younger;

   assign decayed_age = frame_age >> 1;
   assign match       = frame_valid && (frame_page == req_page);
   assign younger     = (frame_idx == '0) || (decayed_age < best_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (ctrl.start) begin
         found_ff <= 1'b0;
      end else if (ctrl.step && match) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.step && match && !found_ff) begin
         hit_idx_ff <= frame_idx;
         hit_age_ff <= decayed_age;
      end
      if (ctrl.step && younger) begin
         min_idx_ff <= frame_idx;
         best_ff    <= decayed_age;
      end
   end

   assign found   = found_ff;
   assign sel_idx = found_ff ? hit_idx_ff : min_idx_ff;
   assign sel_age = found_ff ? hit_age_ff : best_ff;

endmodule

`default_nettype wire

@@ hdl/aging_page_replacement_unit.sv @@
// ----------------------------------------------------------------------------
// aging_page_replacement_unit
// Aging page replacement over a fixed set of frames, one request at a time.
// ----------------------------------------------------------------------------
// Each request is taken in one transfer and answered with one result. The
// frames are scanned one per cycle through the registered read port of the
// frame memory; the unit then drains the last read and updates the chosen
// frame before it takes the next request. The result is formed in the update
// step, which waits while an earlier result has not been taken, and is held
// in an output register, so a new request can be taken while a result still
// waits. A request flagged as the last of a run clears all frames and the
// fault count in the same cycle its result is formed; no clearing pass is
// needed. The history bit register keeps its value across runs and should
// only be written while the unit is idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module aging_page_replacement_unit
   import apr_pkg::*;
#(
   parameter int FRAME_COUNT  = DEF_FRAME_COUNT,
   parameter int PAGE_BITS    = DEF_PAGE_BITS,
   parameter int COUNTER_BITS = DEF_COUNTER_BITS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [PAGE_BITS-1:0]      req_page,
   input  wire logic                      req_last_request,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic                           rsp_hit,
   output logic [FRAME_IDX_BITS-1:0]      rsp_frame_index,
   output logic [FAULT_BITS-1:0]          rsp_fault_count,
   input  wire logic                      csr_write_enable,
   input  wire logic [HIST_BITS-1:0]      csr_write_data
);

   localparam int IDX_BITS = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(FRAME_COUNT - 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_ISSUE  = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic [IDX_BITS-1:0]     rd_idx_ff, rd_idx_in;
   logic                    proc_valid_ff;
   logic [IDX_BITS-1:0]     proc_idx_ff;
   logic [PAGE_BITS-1:0]    req_page_ff;
   logic                    req_last_ff;
   logic [HIST_BITS-1:0]    hist_ff;
   logic [FAULT_BITS-1:0]   fault_total_ff, fault_total_in;
   logic                    rsp_valid_ff;
   logic                    rsp_hit_ff;
   logic [FRAME_IDX_BITS-1:0] rsp_frame_index_ff;
   logic [FAULT_BITS-1:0]   rsp_fault_count_ff;

   logic                    req_xfer;
   logic                    upd_fire;
   logic [FAULT_BITS-1:0]   fault_next;
   logic [COUNTER_BITS-1:0] ref_bit;

   ram_ctrl_type            ram_ctrl;
   scan_ctrl_type           scan_ctrl;
   logic [IDX_BITS-1:0]     wr_addr;
   logic [COUNTER_BITS-1:0] wr_age;
   logic                    rd_valid;
   logic [PAGE_BITS-1:0]    rd_page;
   logic [COUNTER_BITS-1:0] rd_age;
   logic [COUNTER_BITS-1:0] decayed_age;
   logic                    found;
   logic [IDX_BITS-1:0]     sel_idx;
   logic [COUNTER_BITS-1:0] sel_age;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign upd_fire  = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      ref_bit = '0;
      if (32'(hist_ff) < 32'(COUNTER_BITS)) begin
         ref_bit = COUNTER_BITS'(1) << hist_ff;
      end
   end

   always_comb begin
      fault_next = fault_total_ff;
      if (!found && (fault_total_ff != '1)) begin
         fault_next = fault_total_ff + FAULT_BITS'(1);
      end
   end

   always_comb begin
      state_in  = state_ff;
      rd_idx_in = rd_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            rd_idx_in = '0;
            if (req_xfer) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (rd_idx_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end else begin
               rd_idx_in = rd_idx_ff + IDX_BITS'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (upd_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      fault_total_in = fault_total_ff;
      if (upd_fire) begin
         fault_total_in = req_last_ff ? '0 : fault_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rd_idx_ff      <= '0;
         proc_valid_ff  <= 1'b0;
         hist_ff        <= HIST_RESET;
         fault_total_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rd_idx_ff      <= rd_idx_in;
         proc_valid_ff  <= (state_ff == ST_ISSUE);
         fault_total_ff <= fault_total_in;
         if (csr_write_enable) begin
            hist_ff <= csr_write_data;
         end
         if (upd_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      proc_idx_ff <= rd_idx_ff;
      if (req_xfer) begin
         req_page_ff <= req_page;
         req_last_ff <= req_last_request;
      end
      if (upd_fire) begin
         rsp_hit_ff         <= found;
         rsp_frame_index_ff <= FRAME_IDX_BITS'(sel_idx);
         rsp_fault_count_ff <= fault_next;
      end
   end

   // During the scan each decayed age goes back to its frame; the update
   // step then writes the chosen frame.
   always_comb begin
      ram_ctrl.wr_en     = proc_valid_ff || upd_fire;
      ram_ctrl.page_wr   = upd_fire && !found;
      ram_ctrl.set_valid = upd_fire && !found;
      ram_ctrl.clear_all = upd_fire && req_last_ff;
      wr_addr            = (state_ff == ST_UPDATE) ? sel_idx : proc_idx_ff;
      wr_age             = (state_ff == ST_UPDATE) ? (sel_age | ref_bit) : decayed_age;
      scan_ctrl.start    = req_xfer;
      scan_ctrl.step     = proc_valid_ff;
   end

   apr_frame_ram #(
      .FRAME_COUNT  (FRAME_COUNT),
      .PAGE_BITS    (PAGE_BITS),
      .COUNTER_BITS (COUNTER_BITS),
      .IDX_BITS     (IDX_BITS)
   ) u_frame_ram (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ram_ctrl),
      .wr_addr  (wr_addr),
      .wr_page  (req_page_ff),
      .wr_age   (wr_age),
      .rd_addr  (rd_idx_ff),
      .rd_valid (rd_valid),
      .rd_page  (rd_page),
      .rd_age   (rd_age)
   );

   apr_scan_unit #(
      .PAGE_BITS    (PAGE_BITS),
      .COUNTER_BITS (COUNTER_BITS),
      .IDX_BITS     (IDX_BITS)
   ) u_scan_unit (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (scan_ctrl),
      .frame_idx   (proc_idx_ff),
      .frame_valid (rd_valid),
      .frame_page  (rd_page),
      .frame_age   (rd_age),
      .req_page    (req_page_ff),
      .decayed_age (decayed_age),
      .found       (found),
      .sel_idx     (sel_idx),
      .sel_age     (sel_age)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_frame_index = rsp_frame_index_ff;
   assign rsp_fault_count = rsp_fault_count_ff;

   `APR_ASSERT_NEXT(a_xfer_starts_scan, clock, reset, req_xfer, (state_ff == ST_ISSUE) && (rd_idx_ff == '0))
   `APR_ASSERT_NEXT(a_miss_counts_fault, clock, reset, upd_fire && !found, rsp_fault_count_ff != '0)
   `APR_ASSERT_IMPL(a_step_only_in_scan, clock, reset, proc_valid_ff, (state_ff == ST_ISSUE) || (state_ff == ST_DRAIN))

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the aging page replacement unit.
// ----------------------------------------------------------------------------
// A short table of directed requests covers the page extremes, page 0 against
// empty frames, hits, evictions and the end of a run. Random runs follow: each
// run draws from a small pool of pages so that hits and evictions both occur,
// and it ends with a last request. Noise requests with random pages and flags
// are mixed in. The history bit is changed between phases while the unit is
// idle. Both channels stall at random. Each unpinned result is compared with a
// predictor that keeps its own frames, age counters and fault total.
// ----------------------------------------------------------------------------
module tb;
   import apr_pkg::*;

   localparam int FRAME_SLOTS     = DEF_FRAME_COUNT;
   localparam int PAGE_W          = DEF_PAGE_BITS;
   localparam int AGE_W           = DEF_COUNTER_BITS;
   localparam int CYCLE_LIMIT     = 500000;
   localparam int RANDOM_REQUESTS = 1850;
   localparam int PHASES          = 8;
   localparam int DIRECTED_COUNT  = 18;
   localparam int POOL_MAX        = 12;

   typedef struct packed {
      logic                      hit;
      logic [FRAME_IDX_BITS-1:0] frame_index;
      logic [FAULT_BITS-1:0]     fault_count;
   } page_result_type;

   typedef struct packed {
      logic [PAGE_W-1:0] page;
      logic              last_request;
      logic              pinned;
      page_result_type   outcome;
   } directed_row_type;

   localparam page_result_type PREDICTED = '0;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [PAGE_W-1:0]         req_page = '0;
   logic                      req_last_request = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_hit;
   logic [FRAME_IDX_BITS-1:0] rsp_frame_index;
   logic [FAULT_BITS-1:0]     rsp_fault_count;
   logic                      csr_write_enable = 1'b0;
   logic [HIST_BITS-1:0]      csr_write_data = '0;

   logic [PAGE_W-1:0]    resident_page [FRAME_SLOTS];
   logic                 resident [FRAME_SLOTS];
   logic [AGE_W-1:0]     age [FRAME_SLOTS];
   logic [FAULT_BITS-1:0] faults_in_run;
   logic [HIST_BITS-1:0] history_bit_model = HIST_RESET;

   page_result_type pending_results [$];
   int              error_count = 0;
   logic            burst_mode = 1'b0;
   logic            pin_active = 1'b0;
   page_result_type pin_value = '0;
   int              ready_hold = 0;

   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      '{16'h0000, 1'b0, 1'b1, '{1'b0, 3'd0, 32'd1}},
      '{16'h0000, 1'b0, 1'b1, '{1'b1, 3'd0, 32'd1}},
      '{16'hFFFF, 1'b0, 1'b0, PREDICTED},
      '{16'h0001, 1'b0, 1'b0, PREDICTED},
      '{16'h8000, 1'b0, 1'b0, PREDICTED},
      '{16'h5555, 1'b0, 1'b0, PREDICTED},
      '{16'hAAAA, 1'b0, 1'b0, PREDICTED},
      '{16'h00FF, 1'b0, 1'b0, PREDICTED},
      '{16'hFF00, 1'b0, 1'b0, PREDICTED},
      '{16'h1234, 1'b0, 1'b0, PREDICTED},
      '{16'hFFFF, 1'b0, 1'b0, PREDICTED},
      '{16'h0000, 1'b0, 1'b0, PREDICTED},
      '{16'h1234, 1'b1, 1'b0, PREDICTED},
      '{16'hFFFF, 1'b0, 1'b1, '{1'b0, 3'd0, 32'd1}},
      '{16'h0000, 1'b0, 1'b0, PREDICTED},
      '{16'h0000, 1'b1, 1'b0, PREDICTED},
      '{16'h0000, 1'b1, 1'b1, '{1'b0, 3'd0, 32'd1}},
      '{16'h7FFF, 1'b0, 1'b1, '{1'b0, 3'd0, 32'd1}}
   };

   aging_page_replacement_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_page         (req_page),
      .req_last_request (req_last_request),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_frame_index  (rsp_frame_index),
      .rsp_fault_count  (rsp_fault_count),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void clear_run_model();
      for (int i = 0; i < FRAME_SLOTS; i++) begin
         resident_page[i] = '0;
         resident[i] = 1'b0;
         age[i] = '0;
      end
      faults_in_run = '0;
   endfunction

   function automatic page_result_type age_and_place(logic [PAGE_W-1:0] page,
                                                     logic last_request);
      page_result_type  outcome;
      int               sel;
      logic             found;
      logic [AGE_W-1:0] best;
      logic [AGE_W-1:0] ref_mask;
      sel = 0;
      found = 1'b0;
      ref_mask = (history_bit_model < AGE_W) ? (AGE_W'(1) << history_bit_model) : '0;
      for (int i = 0; i < FRAME_SLOTS; i++) begin
         age[i] = age[i] >> 1;
      end
      for (int i = 0; i < FRAME_SLOTS; i++) begin
         if (!found && resident[i] && resident_page[i] == page) begin
            sel = i;
            found = 1'b1;
         end
      end
      if (!found) begin
         if (faults_in_run != '1) begin
            faults_in_run = faults_in_run + FAULT_BITS'(1);
         end
         best = age[0];
         for (int i = 1; i < FRAME_SLOTS; i++) begin
            if (age[i] < best) begin
               best = age[i];
               sel = i;
            end
         end
         resident_page[sel] = page;
         resident[sel] = 1'b1;
      end
      age[sel] = age[sel] | ref_mask;
      outcome.hit = found;
      outcome.frame_index = FRAME_IDX_BITS'(sel);
      outcome.fault_count = faults_in_run;
      if (last_request) begin
         clear_run_model();
      end
      return outcome;
   endfunction

   function automatic int draw_gap();
      return burst_mode ? 0 : $urandom_range(13, 0);
   endfunction

   task automatic send_request(input logic [PAGE_W-1:0] page, input logic last_request,
                               input logic pinned, input page_result_type outcome);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_page <= page;
      req_last_request <= last_request;
      pin_active <= pinned;
      pin_value <= outcome;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_history(input logic [HIST_BITS-1:0] value);
      do @(posedge clock); while ((pending_results.size() != 0) || !req_ready);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      history_bit_model = value;
   endtask

   always @(posedge clock) begin : result_sink
      int stall;
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_hold <= 0;
      end else if (rsp_ready && rsp_valid) begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            ready_hold <= stall;
         end
      end else if (!rsp_ready) begin
         if (ready_hold <= 1) begin
            rsp_ready <= 1'b1;
         end else begin
            ready_hold <= ready_hold - 1;
         end
      end
   end

   always @(posedge clock) begin : scoreboard
      page_result_type predicted;
      page_result_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predicted = age_and_place(req_page, req_last_request);
            pending_results.push_back(pin_active ? pin_value : predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("result transfer with no request outstanding");
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_hit !== want.hit) begin
                  $error("hit: expected %0d, actual %0d", want.hit, rsp_hit);
                  error_count++;
               end
               if (rsp_frame_index !== want.frame_index) begin
                  $error("frame_index: expected %0d, actual %0d",
                         want.frame_index, rsp_frame_index);
                  error_count++;
               end
               if (rsp_fault_count !== want.fault_count) begin
                  $error("fault_count: expected %0d, actual %0d",
                         want.fault_count, rsp_fault_count);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      int                   sent;
      int                   run_len;
      int                   pool_size;
      int                   pick;
      logic [PAGE_W-1:0]    pool [POOL_MAX];
      logic [HIST_BITS-1:0] hist_plan [PHASES];
      clear_run_model();
      hist_plan = '{4'd15, 4'd0, 4'd10, 4'd1, 4'd14, 4'd8, 4'd0, 4'd0};
      hist_plan[6] = HIST_BITS'($urandom_range(15, 0));
      hist_plan[7] = HIST_BITS'($urandom_range(15, 0));
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].page, directed_rows[i].last_request,
                      directed_rows[i].pinned, directed_rows[i].outcome);
      end
      for (int ph = 0; ph < PHASES; ph++) begin
         req_valid <= 1'b0;
         write_history(hist_plan[ph]);
         sent = 0;
         while (sent < RANDOM_REQUESTS / PHASES) begin
            burst_mode <= ($urandom_range(3, 0) == 0);
            if ($urandom_range(9, 0) < 8) begin
               pool_size = $urandom_range(POOL_MAX, 2);
               for (int k = 0; k < pool_size; k++) begin
                  pool[k] = ($urandom_range(3, 0) == 0) ? PAGE_W'($urandom_range(15, 0))
                                                        : PAGE_W'($urandom());
               end
               run_len = $urandom_range(40, 1);
               for (int k = 0; k < run_len; k++) begin
                  pick = $urandom_range(pool_size - 1, 0);
                  send_request(pool[pick], k == run_len - 1, 1'b0, PREDICTED);
               end
            end else begin
               run_len = $urandom_range(6, 1);
               for (int k = 0; k < run_len; k++) begin
                  send_request(PAGE_W'($urandom()), 1'($urandom_range(1, 0)), 1'b0, PREDICTED);
               end
            end
            sent += run_len;
         end
      end
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (FRAME_SLOTS + 3) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
